// ----- rtl/core/fets_pkg.sv -----
package fets_pkg;

   localparam int MAX_ITERATIONS = 510;
   localparam int MAX_DIMENSION  = 1024;
   localparam int FRACTION_BITS  = 28;

   localparam int PIX_W  = 10;
   localparam int DIM_W  = 11;
   localparam int WORD_W = 32;
   localparam int VW_W   = 31;
   localparam int SX_W   = VW_W;
   localparam int DY_W   = SX_W + DIM_W;
   localparam int DEN_W  = DY_W + PIX_W;
   localparam int ADDR_W = 5;

   localparam logic signed [WORD_W-1:0] JULIA_C_REAL_RESET = 32'sd200093238;
   localparam logic signed [WORD_W-1:0] JULIA_C_IMAG_RESET = 32'sd30334898;
   localparam logic [VW_W-1:0]          VIEW_WIDTH_RESET   = 31'd268435456;
   localparam logic [DIM_W-1:0]         COLUMNS_RESET      = 11'd640;
   localparam logic [DIM_W-1:0]         ROWS_RESET         = 11'd480;

   typedef enum logic [2:0] {
      REG_FRACTAL_MODE,
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_VIEW_WIDTH,
      REG_JULIA_C_REAL,
      REG_JULIA_C_IMAG,
      REG_IMAGE_COLUMNS,
      REG_IMAGE_ROWS
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_SX,
      DIV_ZR,
      DIV_ZI
   } div_op_type;

   typedef struct packed {
      logic                     fractal_mode;
      logic signed [WORD_W-1:0] origin_x;
      logic signed [WORD_W-1:0] origin_y;
      logic [VW_W-1:0]          view_width;
      logic signed [WORD_W-1:0] julia_c_real;
      logic signed [WORD_W-1:0] julia_c_imag;
      logic [DIM_W-1:0]         image_columns;
      logic [DIM_W-1:0]         image_rows;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      div_op_type div_start_op;
      logic       div_take;
      div_op_type div_take_op;
      logic       prep;
      logic       map;
      logic       mul;
      logic       step;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic julia;
      logic escape;
      logic at_max;
      logic out_full;
   } stat_type;

   function automatic logic [WORD_W-1:0] sat32(input logic signed [67:0] v);
      if (v > 68'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -68'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/core/fets_req_if.sv -----
interface fets_req_if;
   logic                       valid;
   logic                       ready;
   logic [fets_pkg::PIX_W-1:0] pixel_row;
   logic [fets_pkg::PIX_W-1:0] pixel_col;

   modport source (output valid, output pixel_row, output pixel_col, input ready);
   modport sink (input valid, input pixel_row, input pixel_col, output ready);
endinterface

// ----- rtl/core/fets_rsp_if.sv -----
interface fets_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] shade;
   logic [8:0] iteration_count;
   logic       escaped;

   modport source (output valid, output shade, output iteration_count, output escaped,
                   input ready);
   modport sink (input valid, input shade, input iteration_count, input escaped,
                 output ready);
endinterface

// ----- rtl/core/fets_divider.sv -----
module fets_divider #(
   parameter int NUM_W = 68,
   parameter int DEN_W = 52
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              neg,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic [31:0]       quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [31:0]      q_ff;
   logic             ovf_ff;
   logic             neg_ff;
   logic             zero_ff;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_diff;
   logic             ge;
   logic [DEN_W-1:0] rem_in;
   logic [31:0]      limit;
   logic [31:0]      mag;

   always_comb begin
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      ge       = rem_sh >= {1'b0, den_ff};
      rem_diff = rem_sh - {1'b0, den_ff};
      rem_in   = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      limit    = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag      = (ovf_ff || (q_ff > limit)) ? limit : q_ff;
      if (zero_ff) begin
         quot = '0;
      end else if (neg_ff) begin
         quot = 32'(-mag);
      end else begin
         quot = mag;
      end
   end

   // restoring division, one quotient bit per cycle, sticky overflow above 32 bits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            q_ff    <= '0;
            ovf_ff  <= 1'b0;
            neg_ff  <= neg;
            zero_ff <= (num == '0) || (den == '0);
         end else if (busy_ff) begin
            num_ff <= num_ff << 1;
            rem_ff <= rem_in;
            q_ff   <= {q_ff[30:0], ge};
            ovf_ff <= ovf_ff | q_ff[31];
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
endmodule

// ----- rtl/core/fets_datapath.sv -----
module fets_datapath #(
   parameter int MAX_ITERATIONS = fets_pkg::MAX_ITERATIONS,
   parameter int FRACTION_BITS  = fets_pkg::FRACTION_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fets_pkg::cfg_type          cfg,
   input  logic [fets_pkg::PIX_W-1:0] req_row,
   input  logic [fets_pkg::PIX_W-1:0] req_col,
   input  fets_pkg::cmd_type          cmd,
   output fets_pkg::stat_type         stat,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_shade,
   output logic [8:0]                 rsp_iteration_count,
   output logic                       rsp_escaped
);
   localparam int F     = FRACTION_BITS;
   localparam int NUM_W = 2 * F + 12;
   localparam int DEN_W = fets_pkg::DEN_W;
   localparam int IT_W  = $clog2(MAX_ITERATIONS + 1);
   localparam int PIX_W = fets_pkg::PIX_W;
   localparam int DIM_W = fets_pkg::DIM_W;
   localparam int SX_W  = fets_pkg::SX_W;
   localparam int DY_W  = fets_pkg::DY_W;
   localparam int PR_W  = SX_W + PIX_W;
   localparam logic [63:0] ESC_LIMIT = 64'd4 << F;

   logic [PIX_W-1:0]        row_ff, col_ff;
   logic [SX_W-1:0]         sx_ff;
   logic [DY_W-1:0]         dy_ff;
   logic [PR_W-1:0]         crx_ff, syr_ff, dr_ff;
   logic [DEN_W-1:0]        di_ff;
   logic signed [31:0]      cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [63:0]      prr_ff, pii_ff, pri_ff;
   logic [IT_W-1:0]         iter_ff;
   logic                    out_valid_ff;
   logic [7:0]              shade_ff;
   logic [8:0]              count_ff;
   logic                    esc_ff;

   logic [DIM_W-1:0]        cols_c, rows_c;
   logic [PIX_W-1:0]        hc, hr;
   logic [PIX_W-1:0]        row_in, col_in;
   logic [SX_W-1:0]         sy;
   logic signed [PIX_W+2:0] nr;
   logic signed [PIX_W+4:0] nr3;
   logic [PIX_W+4:0]        nr3_mag;
   logic signed [PIX_W:0]   ni;
   logic [PIX_W:0]          ni_mag;
   logic [NUM_W-1:0]        div_num;
   logic [DEN_W-1:0]        div_den;
   logic                    div_neg;
   logic                    div_done;
   logic [31:0]             div_quot;
   logic [63:0]             mag;
   logic                    escape;
   logic [IT_W-1:0]         count;

   always_comb begin
      cols_c = (32'(cfg.image_columns) > 32'(fets_pkg::MAX_DIMENSION)) ?
               DIM_W'(fets_pkg::MAX_DIMENSION) : cfg.image_columns;
      rows_c = (32'(cfg.image_rows) > 32'(fets_pkg::MAX_DIMENSION)) ?
               DIM_W'(fets_pkg::MAX_DIMENSION) : cfg.image_rows;
      hc     = cols_c[DIM_W-1:1];
      hr     = rows_c[DIM_W-1:1];
      row_in = (32'(req_row) > 32'(fets_pkg::MAX_DIMENSION - 1)) ?
               PIX_W'(fets_pkg::MAX_DIMENSION - 1) : req_row;
      col_in = (32'(req_col) > 32'(fets_pkg::MAX_DIMENSION - 1)) ?
               PIX_W'(fets_pkg::MAX_DIMENSION - 1) : req_col;
      sy     = (rows_c != '0) ? sx_ff : '0;

      // julia numerators: 3*(col - cols/2) and (row - rows/2), split into sign and magnitude
      nr      = $signed({3'b000, col_ff}) - $signed({3'b000, hc});
      nr3     = $signed((PIX_W+5)'(nr)) + $signed((PIX_W+5)'(nr <<< 1));
      nr3_mag = nr3[PIX_W+4] ? (PIX_W+5)'(-nr3) : (PIX_W+5)'(nr3);
      ni      = $signed({1'b0, row_ff}) - $signed({1'b0, hr});
      ni_mag  = ni[PIX_W] ? (PIX_W+1)'(-ni) : (PIX_W+1)'(ni);

      case (cmd.div_start_op)
         fets_pkg::DIV_ZR: begin
            div_num = NUM_W'(nr3_mag) << (2 * F - 1);
            div_den = DEN_W'(dr_ff);
            div_neg = nr3[PIX_W+4];
         end
         fets_pkg::DIV_ZI: begin
            div_num = NUM_W'(ni_mag) << (2 * F);
            div_den = di_ff;
            div_neg = ni[PIX_W];
         end
         default: begin
            div_num = NUM_W'(cfg.view_width);
            div_den = DEN_W'(cols_c);
            div_neg = 1'b0;
         end
      endcase

      mag    = 64'(prr_ff) + 64'(pii_ff);
      escape = (iter_ff != '0) && ((mag >> F) > ESC_LIMIT);
      count  = escape ? iter_ff - 1'b1 : iter_ff;
   end

   fets_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .neg   (div_neg),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
      if (cmd.div_take) begin
         case (cmd.div_take_op)
            fets_pkg::DIV_ZR: begin
               zr_ff <= fets_pkg::sat32($signed(68'($signed(div_quot))) + 68'(cfg.origin_x));
            end
            fets_pkg::DIV_ZI: begin
               zi_ff   <= fets_pkg::sat32($signed(68'($signed(div_quot))) + 68'(cfg.origin_y));
               cr_ff   <= cfg.julia_c_real;
               ci_ff   <= cfg.julia_c_imag;
               iter_ff <= '0;
            end
            default: begin
               sx_ff <= div_quot[SX_W-1:0];
            end
         endcase
      end
      if (cmd.prep) begin
         dy_ff  <= DY_W'(sx_ff) * DY_W'(rows_c);
         crx_ff <= PR_W'(sx_ff) * PR_W'(col_ff);
         syr_ff <= PR_W'(sy) * PR_W'(row_ff);
         dr_ff  <= PR_W'(hc) * PR_W'(cfg.view_width);
      end
      if (cmd.map) begin
         if (cfg.fractal_mode) begin
            di_ff <= DEN_W'(hr) * DEN_W'(dy_ff);
         end else begin
            cr_ff   <= fets_pkg::sat32($signed(68'(crx_ff)) + 68'(cfg.origin_x));
            ci_ff   <= fets_pkg::sat32(68'(cfg.origin_y) + $signed(68'(dy_ff))
                                       - $signed(68'(syr_ff)));
            zr_ff   <= '0;
            zi_ff   <= '0;
            iter_ff <= '0;
         end
      end
      if (cmd.mul) begin
         prr_ff <= zr_ff * zr_ff;
         pii_ff <= zi_ff * zi_ff;
         pri_ff <= zr_ff * zi_ff;
      end
      if (cmd.step) begin
         zr_ff   <= fets_pkg::sat32(68'(prr_ff >>> F) - 68'(pii_ff >>> F) - 68'(cr_ff));
         zi_ff   <= fets_pkg::sat32(68'(pri_ff >>> (F - 1)) - 68'(ci_ff));
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.emit) begin
         count_ff <= (32'(count) > 32'd511) ? 9'd511 : 9'(count);
         shade_ff <= (32'(count >> 1) > 32'd255) ? 8'd255 : 8'(count >> 1);
         esc_ff   <= escape;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.div_done = div_done;
      stat.julia    = cfg.fractal_mode;
      stat.escape   = escape;
      stat.at_max   = (iter_ff == IT_W'(MAX_ITERATIONS));
      stat.out_full = out_valid_ff;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_shade           = shade_ff;
   assign rsp_iteration_count = count_ff;
   assign rsp_escaped         = esc_ff;
endmodule

// ----- rtl/core/fets_ctrl.sv -----
module fets_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fets_pkg::stat_type stat,
   output fets_pkg::cmd_type  cmd
);
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WAIT_SX,
      ST_PREP,
      ST_MAP,
      ST_WAIT_ZR,
      ST_WAIT_ZI,
      ST_MUL,
      ST_STEP,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in          = state_ff;
      req_ready         = 1'b0;
      cmd               = '0;
      cmd.div_start_op  = fets_pkg::DIV_SX;
      cmd.div_take_op   = fets_pkg::DIV_SX;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load      = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_WAIT_SX;
            end
         end
         ST_WAIT_SX: begin
            if (stat.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MAP;
         end
         ST_MAP: begin
            cmd.map = 1'b1;
            if (stat.julia) begin
               cmd.div_start    = 1'b1;
               cmd.div_start_op = fets_pkg::DIV_ZR;
               state_in         = ST_WAIT_ZR;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_WAIT_ZR: begin
            if (stat.div_done) begin
               cmd.div_take     = 1'b1;
               cmd.div_take_op  = fets_pkg::DIV_ZR;
               cmd.div_start    = 1'b1;
               cmd.div_start_op = fets_pkg::DIV_ZI;
               state_in         = ST_WAIT_ZI;
            end
         end
         ST_WAIT_ZI: begin
            if (stat.div_done) begin
               cmd.div_take    = 1'b1;
               cmd.div_take_op = fets_pkg::DIV_ZI;
               state_in        = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (stat.escape || stat.at_max) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DRAIN: begin
            // wait for the output register to free up
            if (!stat.out_full) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/core/fractal_escape_time_shader_unit.sv -----
// channel  | direction | handshake             | payload
// req_ch   | in        | valid / ready         | pixel_row, pixel_col
// rsp_ch   | out       | valid / ready         | shade, iteration_count, escaped
// csr      | in        | apb psel/penable/pwrite | paddr, pwdata, prdata
//
// one item at a time; julia mode runs three divides per item and mandelbrot mode one,
// and each item then loops the iterations (N = iterations run, at most MAX_ITERATIONS);
// the 1-bit-per-cycle divider (2*FRACTION_BITS+12 steps per divide) and the
// multiply/update loop of the iteration (ST_MUL, ST_STEP) set the time per item.
// reset is synchronous; it resets the csr, control state and valid/busy/done flags only.
// a finished item sits in the output register, so the next item is taken
// while the result waits for rsp_ch.ready.
module fractal_escape_time_shader_unit #(
   parameter int MAX_ITERATIONS = fets_pkg::MAX_ITERATIONS,
   parameter int FRACTION_BITS  = fets_pkg::FRACTION_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   fets_req_if.sink                    req_ch,
   fets_rsp_if.source                  rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fets_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   fets_pkg::cfg_type       cfg_ff;
   fets_pkg::csr_index_type csr_idx;
   fets_pkg::cmd_type       cmd;
   fets_pkg::stat_type      stat;
   logic                    csr_wr;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = fets_pkg::csr_index_type'(paddr[fets_pkg::ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fractal_mode  <= 1'b0;
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.view_width    <= fets_pkg::VIEW_WIDTH_RESET;
         cfg_ff.julia_c_real  <= fets_pkg::JULIA_C_REAL_RESET;
         cfg_ff.julia_c_imag  <= fets_pkg::JULIA_C_IMAG_RESET;
         cfg_ff.image_columns <= fets_pkg::COLUMNS_RESET;
         cfg_ff.image_rows    <= fets_pkg::ROWS_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            fets_pkg::REG_FRACTAL_MODE:  cfg_ff.fractal_mode  <= pwdata[0];
            fets_pkg::REG_ORIGIN_X:      cfg_ff.origin_x      <= pwdata;
            fets_pkg::REG_ORIGIN_Y:      cfg_ff.origin_y      <= pwdata;
            fets_pkg::REG_VIEW_WIDTH:    cfg_ff.view_width    <= pwdata[30:0];
            fets_pkg::REG_JULIA_C_REAL:  cfg_ff.julia_c_real  <= pwdata;
            fets_pkg::REG_JULIA_C_IMAG:  cfg_ff.julia_c_imag  <= pwdata;
            fets_pkg::REG_IMAGE_COLUMNS: cfg_ff.image_columns <= pwdata[10:0];
            fets_pkg::REG_IMAGE_ROWS:    cfg_ff.image_rows    <= pwdata[10:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         fets_pkg::REG_FRACTAL_MODE:  prdata = 32'(cfg_ff.fractal_mode);
         fets_pkg::REG_ORIGIN_X:      prdata = cfg_ff.origin_x;
         fets_pkg::REG_ORIGIN_Y:      prdata = cfg_ff.origin_y;
         fets_pkg::REG_VIEW_WIDTH:    prdata = 32'(cfg_ff.view_width);
         fets_pkg::REG_JULIA_C_REAL:  prdata = cfg_ff.julia_c_real;
         fets_pkg::REG_JULIA_C_IMAG:  prdata = cfg_ff.julia_c_imag;
         fets_pkg::REG_IMAGE_COLUMNS: prdata = 32'(cfg_ff.image_columns);
         fets_pkg::REG_IMAGE_ROWS:    prdata = 32'(cfg_ff.image_rows);
         default:                     prdata = '0;
      endcase
   end

   fets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fets_datapath #(
      .MAX_ITERATIONS (MAX_ITERATIONS),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_row             (req_ch.pixel_row),
      .req_col             (req_ch.pixel_col),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_shade           (rsp_ch.shade),
      .rsp_iteration_count (rsp_ch.iteration_count),
      .rsp_escaped         (rsp_ch.escaped)
   );
endmodule
